### rtl/core/ttuc_pkg.sv
`default_nettype none
package ttuc_pkg;

  localparam int unsigned NUM_W = 81;  // widest dividend (ticks to us path)
  localparam int unsigned DIV_W = 33;  // widest divisor (calibrated base)
  localparam int unsigned REM_W = DIV_W + 1;

  localparam logic [2:0] REG_PRESCALE   = 3'd0;
  localparam logic [2:0] REG_CLOCK_MHZ  = 3'd1;
  localparam logic [2:0] REG_BASE       = 3'd2;
  localparam logic [2:0] REG_CORRECTION = 3'd3;
  localparam logic [2:0] REG_LIMIT      = 3'd4;

  localparam logic MODE_US_TO_TICKS = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [31:0] amount;
  } in_t;

  typedef struct packed {
    logic [63:0] converted;
    logic        over_limit;
    logic        bad_base;
  } out_t;

  typedef struct packed {
    logic valid;
    logic mode;
    logic bad;
    logic clk_zero;
  } side_t;

endpackage
`default_nettype wire

### rtl/core/ttuc_cell.sv
`default_nettype none
// One restoring-division step: shift one dividend bit in, emit one quotient bit.
module ttuc_cell (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire ttuc_pkg::side_t              side_i,
  input  wire logic [ttuc_pkg::REM_W-1:0]   rem_i,
  input  wire logic [ttuc_pkg::NUM_W-1:0]   nq_i,
  input  wire logic [ttuc_pkg::DIV_W-1:0]   d_mode0,
  input  wire logic [ttuc_pkg::DIV_W-1:0]   d_mode1,
  output ttuc_pkg::side_t                   side_o,
  output logic [ttuc_pkg::REM_W-1:0]        rem_o,
  output logic [ttuc_pkg::NUM_W-1:0]        nq_o
);

  logic [ttuc_pkg::REM_W-1:0] shifted;
  logic [ttuc_pkg::REM_W-1:0] dvs;
  logic                       ge;
  ttuc_pkg::side_t            side_r;
  logic [ttuc_pkg::REM_W-1:0] rem_r;
  logic [ttuc_pkg::NUM_W-1:0] nq_r;

  always_comb begin
    dvs     = {1'b0, (side_i.mode == ttuc_pkg::MODE_US_TO_TICKS) ? d_mode0 : d_mode1};
    shifted = {rem_i[ttuc_pkg::REM_W-2:0], nq_i[ttuc_pkg::NUM_W-1]};
    ge      = (shifted >= dvs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      rem_r  <= ge ? (shifted - dvs) : shifted;
      nq_r   <= {nq_i[ttuc_pkg::NUM_W-2:0], ge};
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;

endmodule
`default_nettype wire

### rtl/core/ttuc_chain.sv
`default_nettype none
// Row of division cells, one quotient bit per cell, MSB first.
module ttuc_chain (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire ttuc_pkg::side_t             side_i,
  input  wire logic [ttuc_pkg::NUM_W-1:0]  num_i,
  input  wire logic [ttuc_pkg::DIV_W-1:0]  d_mode0,
  input  wire logic [ttuc_pkg::DIV_W-1:0]  d_mode1,
  output ttuc_pkg::side_t                  side_o,
  output logic [ttuc_pkg::NUM_W-1:0]       quo_o
);

  ttuc_pkg::side_t            side_w [ttuc_pkg::NUM_W+1];
  logic [ttuc_pkg::REM_W-1:0] rem_w  [ttuc_pkg::NUM_W+1];
  logic [ttuc_pkg::NUM_W-1:0] nq_w   [ttuc_pkg::NUM_W+1];

  // Valid bits ride separately so reset clears the row.
  logic [ttuc_pkg::NUM_W-1:0] vld_r;

  assign side_w[0] = side_i;
  assign rem_w[0]  = '0;
  assign nq_w[0]   = num_i;

  for (genvar g = 0; g < ttuc_pkg::NUM_W; g++) begin : g_cell
    ttuc_cell u_cell (
      .clk    (clk),
      .en     (en),
      .side_i (side_w[g]),
      .rem_i  (rem_w[g]),
      .nq_i   (nq_w[g]),
      .d_mode0(d_mode0),
      .d_mode1(d_mode1),
      .side_o (side_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .nq_o   (nq_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ttuc_pkg::NUM_W-2:0], side_i.valid};
    end
  end

  always_comb begin
    side_o       = side_w[ttuc_pkg::NUM_W];
    side_o.valid = vld_r[ttuc_pkg::NUM_W-1];
    quo_o        = nq_w[ttuc_pkg::NUM_W];
  end

endmodule
`default_nettype wire

### rtl/core/timer_time_unit_converter.sv
`default_nettype none
// Timer time-unit converter.
// Input channel (in_valid/in_ready/in_data): one request per item, mode 0
// turns microseconds into timer ticks, mode 1 turns ticks into microseconds.
// Result channel (out_valid/out_ready/out_data): one result per request, in
// request order, with converted value (saturated to 64 bits), over_limit and
// bad_base.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write registers only while no request is in flight.
// Pipeline: 166 register stages (one multiply stage, two 81-cell division
// rows, two stages for the split second multiply, the output register).
// Throughput: one request per cycle while the receiver does not stall; each
// division row retires one quotient bit per cell and passes its partial
// remainder on.
// Reset clears the configuration to its defaults and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops until the result is taken.
module timer_time_unit_converter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ttuc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ttuc_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);

  logic [15:0] prescale_r;
  logic [7:0]  clock_mhz_r;
  logic [31:0] base_r;
  logic [31:0] corr_r;
  logic [31:0] limit_r;

  logic [33:0] cal_base;   // signed base_period + base_correction
  logic [16:0] divs;
  logic        bad;
  logic        adv;

  ttuc_pkg::side_t s0_side;
  ttuc_pkg::side_t s0_side_r;
  logic [64:0]     p1_r;
  logic [32:0]     m1;

  ttuc_pkg::side_t              c1_side, c2_side;
  logic [ttuc_pkg::NUM_W-1:0]   q1, q2;

  ttuc_pkg::side_t m1_side_r, m2_side_r;
  logic [31:0]     m2;
  logic [64:0]     lo_r;
  logic [63:0]     hi_r;
  logic [ttuc_pkg::NUM_W-1:0] p2_r;

  logic            out_valid_r;
  ttuc_pkg::out_t  out_data_r;
  ttuc_pkg::out_t  res;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;   // hold everything on a stall
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= '0;
      clock_mhz_r <= 8'd1;
      base_r      <= 32'd1;
      corr_r      <= '0;
      limit_r     <= 32'd65535;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttuc_pkg::REG_PRESCALE:   prescale_r  <= cfg_data[15:0];
        ttuc_pkg::REG_CLOCK_MHZ:  clock_mhz_r <= cfg_data[7:0];
        ttuc_pkg::REG_BASE:       base_r      <= cfg_data;
        ttuc_pkg::REG_CORRECTION: corr_r      <= cfg_data;
        ttuc_pkg::REG_LIMIT:      limit_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal_base = {2'b00, base_r} + {{2{corr_r[31]}}, corr_r};
    divs     = {1'b0, prescale_r} + 17'd1;
    bad      = cal_base[33] || (cal_base == '0) || (base_r == '0);
    m1       = (in_data.mode == ttuc_pkg::MODE_US_TO_TICKS) ? cal_base[32:0]
                                                             : {16'b0, divs};
    s0_side.valid    = in_valid;
    s0_side.mode     = in_data.mode;
    s0_side.bad      = bad;
    s0_side.clk_zero = (clock_mhz_r == '0);
  end

  // First multiply: amount by calibrated base (mode 0) or prescale divisor (mode 1).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_side_r.valid <= 1'b0;
    end else if (adv) begin
      s0_side_r <= s0_side;
      p1_r      <= in_data.amount * m1;
    end
  end

  // First divide: by base_period (mode 0) or clock_mhz (mode 1).
  ttuc_chain u_div1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .side_i (s0_side_r),
    .num_i  ({16'b0, p1_r}),
    .d_mode0({1'b0, base_r}),
    .d_mode1({25'b0, clock_mhz_r}),
    .side_o (c1_side),
    .quo_o  (q1)
  );

  assign m2 = (c1_side.mode == ttuc_pkg::MODE_US_TO_TICKS) ? {24'b0, clock_mhz_r} : base_r;

  // Second multiply, split into two partial products, summed a stage later.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_side_r.valid <= 1'b0;
      m2_side_r.valid <= 1'b0;
    end else if (adv) begin
      m1_side_r <= c1_side;
      lo_r      <= q1[32:0] * m2;
      hi_r      <= q1[64:33] * m2;
      m2_side_r <= m1_side_r;
      p2_r      <= {16'b0, lo_r} + {hi_r[47:0], 33'b0};
    end
  end

  // Second divide: by prescale divisor (mode 0) or calibrated base (mode 1).
  ttuc_chain u_div2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .side_i (m2_side_r),
    .num_i  (p2_r),
    .d_mode0({16'b0, divs}),
    .d_mode1(cal_base[32:0]),
    .side_o (c2_side),
    .quo_o  (q2)
  );

  always_comb begin
    res.converted  = (q2[ttuc_pkg::NUM_W-1:64] != '0) ? '1 : q2[63:0];
    res.over_limit = (c2_side.mode == ttuc_pkg::MODE_US_TO_TICKS) &&
                     (q2 > {49'b0, limit_r});
    res.bad_base   = 1'b0;
    if (c2_side.bad) begin
      res.converted  = '0;
      res.over_limit = 1'b0;
      res.bad_base   = 1'b1;
    end else if (c2_side.mode != ttuc_pkg::MODE_US_TO_TICKS && c2_side.clk_zero) begin
      res.converted = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c2_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### rtl/core/ttuc_checker.sv
`default_nettype none
module ttuc_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire ttuc_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_base |-> out_data.converted == '0 && !out_data.over_limit)
    else $error("bad base result not cleared");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind timer_time_unit_converter ttuc_checker u_ttuc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire

### dv/timer_time_unit_converter_test.sv
`default_nettype none
module timer_time_unit_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 200;     // above the 166-stage pipeline depth
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_REQS    = 200;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  ttuc_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ttuc_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;

  // Shadow copy of the register file, updated at each accepted write.
  logic [15:0]        prescale;
  logic [7:0]         clk_mhz;
  logic [31:0]        base_period;
  logic signed [31:0] base_corr;
  logic [31:0]        tick_limit;

  ttuc_pkg::out_t expected_results[$];
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  bit          steady = 1'b0;   // suppress all idling on both channels

  timer_time_unit_converter i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Exact conversion at 128 bits; saturate the result to 64 bits.
  function automatic ttuc_pkg::out_t convert(ttuc_pkg::in_t req);
    ttuc_pkg::out_t r;
    longint         cal_base;
    logic [127:0]   num, q;
    r = '0;
    cal_base = longint'(base_period) + longint'(base_corr);
    if (cal_base <= 0 || base_period == 0) begin
      r.bad_base = 1'b1;
      return r;
    end
    if (req.mode == ttuc_pkg::MODE_US_TO_TICKS) begin
      num = 128'(req.amount) * 128'(cal_base);
      q   = num / 128'(base_period);
      q   = (q * 128'(clk_mhz)) / (128'(prescale) + 128'd1);
      r.over_limit = q > 128'(tick_limit);
    end else if (clk_mhz == 0) begin
      q = {64'd0, {64{1'b1}}};
    end else begin
      q = (128'(req.amount) * (128'(prescale) + 128'd1)) / 128'(clk_mhz);
      q = (q * 128'(base_period)) / 128'(cal_base);
    end
    r.converted = (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
    return r;
  endfunction

  // Hold the request until accepted; on accept, queue its expected result.
  // in_valid stays high into the next request unless a gap is taken.
  task automatic send_request(ttuc_pkg::in_t req, bit known, ttuc_pkg::out_t given);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(known ? given : convert(req));
    if (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every result, then let the pipeline empty out.
  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ttuc_pkg::REG_PRESCALE:   prescale    = value[15:0];
      ttuc_pkg::REG_CLOCK_MHZ:  clk_mhz     = value[7:0];
      ttuc_pkg::REG_BASE:       base_period = value;
      ttuc_pkg::REG_CORRECTION: base_corr   = value;
      ttuc_pkg::REG_LIMIT:      tick_limit  = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: stall at random, check each accepted result against the oldest
  // expectation.
  always @(posedge clk) begin
    ttuc_pkg::out_t exp_r;
    out_ready <= steady || ($urandom_range(99) >= 11);
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_data);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.converted !== exp_r.converted) begin
          $error("converted: expected %h, got %h", exp_r.converted, out_data.converted);
          n_errors++;
        end
        if (out_data.over_limit !== exp_r.over_limit) begin
          $error("over_limit: expected %b, got %b", exp_r.over_limit, out_data.over_limit);
          n_errors++;
        end
        if (out_data.bad_base !== exp_r.bad_base) begin
          $error("bad_base: expected %b, got %b", exp_r.bad_base, out_data.bad_base);
          n_errors++;
        end
      end
    end
  end

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] value;
    logic        mode;
    logic [31:0] amount;
    bit          known;
    logic [63:0] conv;
    bit          over;
    bit          bad;
  } row_t;

  localparam logic M0 = ttuc_pkg::MODE_US_TO_TICKS;
  localparam logic M1 = ~ttuc_pkg::MODE_US_TO_TICKS;
  localparam logic [63:0] ALL1 = {64{1'b1}};

  // Directed rows: reset defaults pass amounts straight through, then the
  // unusable calibrated base, zero clock and the register extremes.
  row_t directed[] = '{
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd0,          1, 64'd0,          0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd65535,      1, 64'd65535,      0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd65536,      1, 64'd65536,      1, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'hFFFF_FFFF,  1, 64'hFFFF_FFFF,  1, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M1, 32'hFFFF_FFFF,  1, 64'hFFFF_FFFF,  0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M1, 32'd0,          1, 64'd0,          0, 0},
    '{1, ttuc_pkg::REG_CORRECTION, 32'hFFFF_FFFF, M0, 0, 0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd1234,       1, 64'd0,          0, 1},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M1, 32'd1234,       1, 64'd0,          0, 1},
    '{1, ttuc_pkg::REG_CORRECTION, 32'd0, M0, 0, 0, 0, 0, 0},
    '{1, ttuc_pkg::REG_BASE, 32'd0, M0, 0, 0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd5,          1, 64'd0,          0, 1},
    '{1, ttuc_pkg::REG_BASE, 32'd1000, M0, 0, 0, 0, 0, 0},
    '{1, ttuc_pkg::REG_CLOCK_MHZ, 32'd0, M0, 0, 0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd777,        1, 64'd0,          0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M1, 32'd777,        1, ALL1,           0, 0},
    '{1, ttuc_pkg::REG_CLOCK_MHZ, 32'd255, M0, 0, 0, 0, 0, 0},
    '{1, ttuc_pkg::REG_PRESCALE, 32'hFFFF, M0, 0, 0, 0, 0, 0},
    '{1, ttuc_pkg::REG_BASE, 32'hFFFF_FFFF, M0, 0, 0, 0, 0, 0},
    '{1, ttuc_pkg::REG_CORRECTION, 32'h7FFF_FFFF, M0, 0, 0, 0, 0, 0},
    '{1, ttuc_pkg::REG_LIMIT, 32'd0, M0, 0, 0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'hFFFF_FFFF,  0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M1, 32'hFFFF_FFFF,  0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'd0,          1, 64'd0,          0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M1, 32'd1,          0, 0, 0, 0},
    '{1, ttuc_pkg::REG_CORRECTION, 32'h8000_0000, M0, 0, 0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'hAAAA_AAAA,  0, 0, 0, 0},
    '{1, ttuc_pkg::REG_LIMIT, 32'hFFFF_FFFF, M0, 0, 0, 0, 0, 0},
    '{0, ttuc_pkg::REG_PRESCALE, 0, M0, 32'h5555_5555,  0, 0, 0, 0}
  };

  initial begin
    ttuc_pkg::in_t  req;
    ttuc_pkg::out_t given;
    logic [31:0]    bp;
    prescale    = '0;
    clk_mhz     = 8'd1;
    base_period = 32'd1;
    base_corr   = '0;
    tick_limit  = 32'd65535;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        req.mode   = directed[i].mode;
        req.amount = directed[i].amount;
        given = '{converted: directed[i].conv, over_limit: directed[i].over,
                  bad_base: directed[i].bad};
        send_request(req, directed[i].known, given);
      end
    end

    // Random phases: fresh settings each phase, mostly usable ones.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      steady = (p == 3);
      write_reg(ttuc_pkg::REG_PRESCALE, ($urandom_range(3) == 0) ? 32'hFFFF :
                ($urandom_range(1) ? $urandom_range(0, 99) : $urandom));
      write_reg(ttuc_pkg::REG_CLOCK_MHZ,
                ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1, 255));
      case ($urandom_range(5))
        0:       bp = 32'hFFFF_FFFF;
        1:       bp = $urandom_range(1, 50);
        default: bp = $urandom;
      endcase
      write_reg(ttuc_pkg::REG_BASE, bp);
      // Keep the calibrated base positive most of the time.
      write_reg(ttuc_pkg::REG_CORRECTION, ($urandom_range(5) == 0) ? $urandom :
                32'($urandom_range(0, 2000)) - 32'd1000);
      write_reg(ttuc_pkg::REG_LIMIT, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
      for (int k = 0; k < PHASE_REQS; k++) begin
        req.mode = $urandom_range(1);
        case ($urandom_range(7))
          0:       req.amount = 32'hFFFF_FFFF;
          1:       req.amount = '0;
          2:       req.amount = $urandom_range(0, 1000);
          default: req.amount = $urandom;
        endcase
        send_request(req, 1'b0, '0);
      end
    end

    steady = 1'b0;
    drain();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/core/ttuc_pkg.sv
rtl/core/ttuc_cell.sv
rtl/core/ttuc_chain.sv
rtl/core/timer_time_unit_converter.sv
rtl/core/ttuc_checker.sv
dv/timer_time_unit_converter_test.sv
